>>> design/assert_macros.svh
// Assertion macros used by the disk head scheduler unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define DHS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define DHS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/dhs_pkg.sv
// Package with the types, codes and helper functions of the disk head scheduler.
package dhs_pkg;

    localparam int TRACK_W = 12;
    localparam int MOVE_W  = 17;
    localparam int TC_W    = 13;
    localparam int MODE_W  = 3;

    localparam logic [MODE_W-1:0] MODE_FCFS  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SSTF  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SCAN  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CSCAN = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LOOK  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLOOK = 3'd5;

    localparam logic [1:0] REG_MODE        = 2'd0;
    localparam logic [1:0] REG_TRACK_COUNT = 2'd1;
    localparam logic [1:0] REG_START_TRACK = 2'd2;

    localparam logic [MODE_W-1:0] MODE_RESET        = 3'd0;
    localparam logic [TC_W-1:0]   TRACK_COUNT_RESET = 13'd200;
    localparam logic [TRACK_W-1:0] START_RESET      = 12'd50;

    typedef struct packed {
        logic [TRACK_W-1:0] request_track;
        logic               batch_end;
    } req_t;

    typedef struct packed {
        logic [TRACK_W-1:0] visit_track;
        logic [MOVE_W-1:0]  movement_so_far;
        logic               final_visit;
        logic               overflow;
    } vis_t;

    // Highest valid track for a given track count, with the count held to its legal range.
    function automatic logic [TRACK_W-1:0] end_track(input logic [TC_W-1:0] tc);
        logic [TC_W-1:0] top;
        top = TC_W'(1) << TRACK_W;
        if (tc < TC_W'(2))
            return TRACK_W'(1);
        else if (tc > top)
            return {TRACK_W{1'b1}};
        else
            return TRACK_W'(tc - TC_W'(1));
    endfunction

    function automatic logic [TRACK_W-1:0] track_dist(input logic [TRACK_W-1:0] a,
                                                      input logic [TRACK_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

>>> design/dhs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dhs_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

>>> design/disk_head_scheduler_unit.sv
// Top level of the disk head scheduler: request store, scan sequencer and output register.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+------------------------------
//   in       | in        | in_valid / in_stall   | in_data  (request_track, batch_end)
//   out      | out       | out_valid / out_stall | out_data (visit, movement, flags)
//   config   | in        | APB psel/penable      | mode, track_count, start_track
//
// A request without batch_end is taken while the unit is idle and stored in the request RAM;
// once the RAM is full, further requests are dropped and the drop flag is set.
// A request with batch_end starts the schedule: each requested track is chosen by a scan
// of the stored requests through the single RAM read port.
// in_stall stays high from the closing request until the final visit is loaded.
// out_stall freezes the output register; the next visit is computed meanwhile and then waits in S_OUT.
// Reset clears the request count, the served mask, the drop flag and the other control registers.
module disk_head_scheduler_unit #(
    parameter int MAX_REQUESTS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  dhs_pkg::req_t in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output dhs_pkg::vis_t out_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    import dhs_pkg::*;

    localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;

    localparam logic [1:0] PH_UP   = 2'd0;
    localparam logic [1:0] PH_DOWN = 2'd1;
    localparam logic [1:0] PH_WRAP = 2'd2;

    localparam logic [1:0] K_START = 2'd0;
    localparam logic [1:0] K_REQ   = 2'd1;
    localparam logic [1:0] K_END   = 2'd2;
    localparam logic [1:0] K_ZERO  = 2'd3;

    // Configuration registers.
    logic [MODE_W-1:0]  mode_reg;
    logic [TC_W-1:0]    tc_reg;
    logic [TRACK_W-1:0] start_cfg_reg;

    // Control state.
    logic [2:0]              state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [CNT_W-1:0]        rem_reg, rem_next;
    logic [MAX_REQUESTS-1:0] served_reg, served_next;
    logic                    drop_reg, drop_next;
    logic [1:0]              phase_reg, phase_next;
    logic [1:0]              kind_reg, kind_next;
    logic                    hit_end_reg, hit_end_next;
    logic [CNT_W-1:0]        rd_idx_reg, rd_idx_next;
    logic                    cmp_vld_reg, cmp_vld_next;
    logic                    found_reg, found_next;
    logic                    out_vld_reg, out_vld_next;

    // Payload registers.
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [TRACK_W-1:0] best_v_reg, best_v_next;
    logic [TRACK_W-1:0] best_d_reg, best_d_next;
    logic [IDX_W-1:0]   best_i_reg, best_i_next;
    logic [TRACK_W-1:0] nv_reg, nv_next;
    logic [IDX_W-1:0]   ni_reg, ni_next;
    logic [TRACK_W-1:0] start_reg, start_next;
    logic [TRACK_W-1:0] prev_reg, prev_next;
    logic [MOVE_W-1:0]  moved_reg, moved_next;
    vis_t               out_reg, out_next;

    // RAM port and shared compare unit signals.
    logic               ram_we;
    logic [TRACK_W-1:0] ram_wdata;
    logic [TRACK_W-1:0] ram_rdata;

    logic [MODE_W-1:0]  mode_eff;
    logic [TRACK_W-1:0] end_trk;
    logic [TRACK_W-1:0] req_clamp;
    logic [TRACK_W-1:0] cand_d;
    logic               cand_ok;
    logic               cand_take;
    logic               slot_free;
    logic               in_acc;
    logic               issue;
    logic               is_final;
    logic [CNT_W-1:0]   rem_after;
    logic               cfg_wr;

    // ------------------------------------------------------------------
    // Configuration port. Writes land at the access phase; reads are free.
    // ------------------------------------------------------------------
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_RESET;
            tc_reg        <= TRACK_COUNT_RESET;
            start_cfg_reg <= START_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_MODE:        mode_reg      <= pwdata[MODE_W-1:0];
                REG_TRACK_COUNT: tc_reg        <= pwdata[TC_W-1:0];
                REG_START_TRACK: start_cfg_reg <= pwdata[TRACK_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_MODE:        prdata = 32'(mode_reg);
            REG_TRACK_COUNT: prdata = 32'(tc_reg);
            REG_START_TRACK: prdata = 32'(start_cfg_reg);
            default:         prdata = 32'd0;
        endcase
    end

    // Unused mode codes behave as first come, first served.
    assign mode_eff  = (mode_reg > MODE_CLOOK) ? MODE_FCFS : mode_reg;
    assign end_trk   = end_track(tc_reg);
    assign req_clamp = (in_data.request_track > end_trk) ? end_trk : in_data.request_track;

    // ------------------------------------------------------------------
    // Request store.
    // ------------------------------------------------------------------
    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign ram_we    = in_acc && (cnt_reg < CNT_W'(MAX_REQUESTS));
    assign ram_wdata = req_clamp;
    assign issue     = (state_reg == S_SCAN) && (rd_idx_reg < cnt_reg);

    dhs_ram #(
        .WIDTH (TRACK_W),
        .DEPTH (MAX_REQUESTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[IDX_W-1:0]),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Shared compare unit: rates the entry just read against the best so far.
    // Nearest-first ranks by distance to the head, the sweeps rank by track,
    // and arrival order simply keeps the first unserved entry.
    // ------------------------------------------------------------------
    assign cand_d = track_dist(ram_rdata, prev_reg);

    always_comb
    begin
        cand_ok = !served_reg[cmp_idx_reg];
        if ((phase_reg == PH_UP) && (mode_eff != MODE_FCFS) && (mode_eff != MODE_SSTF))
        begin
            cand_ok = cand_ok && (ram_rdata >= start_reg);
        end
        case (mode_eff)
            MODE_FCFS: cand_take = cand_ok && !found_reg;
            MODE_SSTF: cand_take = cand_ok && (!found_reg || (cand_d < best_d_reg));
            default:
            begin
                if (phase_reg == PH_DOWN)
                    cand_take = cand_ok && (!found_reg || (ram_rdata > best_v_reg));
                else
                    cand_take = cand_ok && (!found_reg || (ram_rdata < best_v_reg));
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Last-visit detection for the visit waiting in nv_reg.
    // ------------------------------------------------------------------
    assign slot_free = !out_vld_reg || !out_stall;
    assign rem_after = (kind_reg == K_REQ) ? (rem_reg - CNT_W'(1)) : rem_reg;

    always_comb
    begin
        case (kind_reg)
            K_START: is_final = 1'b0;
            K_REQ:
            begin
                is_final = (rem_after == '0);
                if (phase_reg == PH_UP)
                begin
                    if (mode_eff == MODE_CSCAN)
                        is_final = 1'b0;
                    else if ((mode_eff == MODE_SCAN) && !hit_end_reg && (nv_reg != end_trk))
                        is_final = 1'b0;
                end
            end
            K_END:   is_final = (mode_eff == MODE_SCAN) && (rem_reg == '0);
            K_ZERO:  is_final = (rem_reg == '0);
            default: is_final = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        served_next  = served_reg;
        drop_next    = drop_reg;
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        hit_end_next = hit_end_reg;
        rd_idx_next  = rd_idx_reg;
        cmp_vld_next = issue;
        cmp_idx_next = rd_idx_reg[IDX_W-1:0];
        found_next   = found_reg;
        best_v_next  = best_v_reg;
        best_d_next  = best_d_reg;
        best_i_next  = best_i_reg;
        nv_next      = nv_reg;
        ni_next      = ni_reg;
        start_next   = start_reg;
        prev_next    = prev_reg;
        moved_next   = moved_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg && out_stall;

        if (cmp_vld_reg && cand_take)
        begin
            found_next  = 1'b1;
            best_v_next = ram_rdata;
            best_d_next = cand_d;
            best_i_next = cmp_idx_reg;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (ram_we)
                        cnt_next = cnt_reg + CNT_W'(1);
                    else
                        drop_next = 1'b1;
                    if (in_data.batch_end)
                    begin
                        start_next   = (start_cfg_reg > end_trk) ? end_trk : start_cfg_reg;
                        prev_next    = start_next;
                        nv_next      = start_next;
                        kind_next    = K_START;
                        moved_next   = '0;
                        phase_next   = PH_UP;
                        hit_end_next = 1'b0;
                        rem_next     = cnt_next;
                        state_next   = S_OUT;
                    end
                end
            end

            S_SCAN:
            begin
                if (issue)
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                else if (!cmp_vld_reg)
                    state_next = S_DEC;
            end

            S_DEC:
            begin
                state_next = S_OUT;
                if (found_reg)
                begin
                    nv_next   = best_v_reg;
                    ni_next   = best_i_reg;
                    kind_next = K_REQ;
                end
                else if ((mode_eff == MODE_SCAN) && !hit_end_reg)
                begin
                    nv_next    = end_trk;
                    kind_next  = K_END;
                    phase_next = PH_DOWN;
                end
                else if (mode_eff == MODE_CSCAN)
                begin
                    nv_next    = end_trk;
                    kind_next  = K_END;
                    phase_next = PH_WRAP;
                end
                else
                begin
                    // The sweep turns around without an end stop and rescans.
                    phase_next  = (mode_eff == MODE_CLOOK) ? PH_WRAP : PH_DOWN;
                    state_next  = S_SCAN;
                    rd_idx_next = '0;
                    found_next  = 1'b0;
                end
            end

            S_OUT:
            begin
                if (slot_free)
                begin
                    out_vld_next                 = 1'b1;
                    out_next.visit_track         = nv_reg;
                    out_next.movement_so_far     = moved_reg + MOVE_W'(track_dist(nv_reg, prev_reg));
                    out_next.final_visit         = is_final;
                    out_next.overflow            = drop_reg;
                    moved_next                   = out_next.movement_so_far;
                    prev_next                    = nv_reg;
                    rem_next                     = rem_after;
                    if (kind_reg == K_REQ)
                    begin
                        served_next[ni_reg] = 1'b1;
                        if ((phase_reg == PH_UP) && (nv_reg == end_trk))
                            hit_end_next = 1'b1;
                    end
                    if (is_final)
                    begin
                        state_next  = S_IDLE;
                        cnt_next    = '0;
                        served_next = '0;
                        drop_next   = 1'b0;
                    end
                    else if ((kind_reg == K_END) && (mode_eff == MODE_CSCAN))
                    begin
                        nv_next   = '0;
                        kind_next = K_ZERO;
                    end
                    else
                    begin
                        state_next  = S_SCAN;
                        rd_idx_next = '0;
                        found_next  = 1'b0;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            rem_reg     <= '0;
            served_reg  <= '0;
            drop_reg    <= 1'b0;
            phase_reg   <= PH_UP;
            kind_reg    <= K_START;
            hit_end_reg <= 1'b0;
            rd_idx_reg  <= '0;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rem_reg     <= rem_next;
            served_reg  <= served_next;
            drop_reg    <= drop_next;
            phase_reg   <= phase_next;
            kind_reg    <= kind_next;
            hit_end_reg <= hit_end_next;
            rd_idx_reg  <= rd_idx_next;
            cmp_vld_reg <= cmp_vld_next;
            found_reg   <= found_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        best_v_reg  <= best_v_next;
        best_d_reg  <= best_d_next;
        best_i_reg  <= best_i_next;
        nv_reg      <= nv_next;
        ni_reg      <= ni_next;
        start_reg   <= start_next;
        prev_reg    <= prev_next;
        moved_reg   <= moved_next;
        out_reg     <= out_next;
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `include "assert_macros.svh"

    `DHS_ASSERT_ALWAYS(a_cmp_in_scan, cmp_vld_reg |-> (state_reg == S_SCAN), "compare outside scan")
    `DHS_ASSERT(a_rem_bound, rem_reg <= cnt_reg, "remaining count exceeds stored count")
    `DHS_ASSERT(a_served_sum, (state_reg != S_IDLE) |-> ((CNT_W + 1)'($countones(served_reg)) + (CNT_W + 1)'(rem_reg) == (CNT_W + 1)'(cnt_reg)), "served mask and remaining count disagree")
    `DHS_ASSERT(a_final_idle, ((state_reg == S_OUT) && slot_free && is_final) |=> ((state_reg == S_IDLE) && (cnt_reg == '0) && (served_reg == '0)), "batch state not cleared after final visit")

endmodule
